>>> rtl/sws_pkg.sv
// sws_pkg: shared types and constants for the shell word splitter.
// Kind, character, bracket and quote, and action codes and control structs.
// No dependencies.
`timescale 1ns / 1ps

package sws_pkg;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_EOI  = 2'd2;

    localparam logic [2:0] ACT_KEPT      = 3'd0;
    localparam logic [2:0] ACT_CLOSE     = 3'd1;
    localparam logic [2:0] ACT_SYNTAX    = 3'd2;
    localparam logic [2:0] ACT_UNMATCHED = 3'd3;
    localparam logic [2:0] ACT_OVERFLOW  = 3'd4;

    localparam logic [2:0] CODE_PAREN  = 3'd0;
    localparam logic [2:0] CODE_SQUARE = 3'd1;
    localparam logic [2:0] CODE_CURLY  = 3'd2;
    localparam logic [2:0] CODE_BTICK  = 3'd3;
    localparam logic [2:0] CODE_SQUOTE = 3'd4;
    localparam logic [2:0] CODE_DQUOTE = 3'd5;
    localparam logic [2:0] CODE_NONE   = 3'd7;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LSQUARE   = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RSQUARE   = 8'h5D;
    localparam logic [7:0] CH_BTICK     = 8'h60;
    localparam logic [7:0] CH_LCURLY    = 8'h7B;
    localparam logic [7:0] CH_RCURLY    = 8'h7D;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stack_stat;

    typedef struct packed {
        logic [2:0] action;
        t_stack_op  op;
        logic       clear;
        logic       esc_next;
        logic [2:0] push_code;
    } t_step;

endpackage

>>> rtl/shell_word_splitter.sv
// shell_word_splitter: top level of the shell word splitter.
// Instantiates sws_ctrl and a row of sws_cell entries; depends on sws_pkg.
`timescale 1ns / 1ps

// Takes one character beat per cycle while o_ready is high and returns a
// result beat for each in the cycle after acceptance through a single output
// register; a new beat is accepted in the same cycle the pending result is
// taken, so the sustained rate is one beat per clock while i_ready holds. The
// open brackets and quotes sit in a row of STACK_DEPTH shift cells whose
// first cell is the stack top; a push or pop shifts the row by one place, and
// the classify logic reads only the top cell, the fill count and the escape
// flag. o_nesting carries the low five bits of the fill count after the beat.
module shell_word_splitter
    import sws_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_key,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_action,
    output logic [7:0] o_key_out,
    output logic [4:0] o_nesting
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_esc;
    logic          n_esc;
    logic          r_out_valid;
    logic [2:0]    r_action;
    logic [7:0]    r_key;
    logic [4:0]    r_nesting;

    logic          w_accept;
    t_stack_stat   w_stat;
    t_step         w_step;
    t_stack_op     w_op;
    logic [2:0]    w_code [STACK_DEPTH];
    logic [CW+4:0] w_count_ext;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    assign w_stat.empty = (r_count == '0);
    assign w_stat.full  = (r_count == FULL_COUNT);

    sws_ctrl u_ctrl (
        .i_kind (i_kind),
        .i_key  (i_key),
        .i_top  (w_code[0]),
        .i_stat (w_stat),
        .i_esc  (r_esc),
        .o_step (w_step)
    );

    assign w_op.push = w_accept && w_step.op.push;
    assign w_op.pop  = w_accept && w_step.op.pop;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [2:0] w_above;
        logic [2:0] w_below;
        if (g == 0) begin : g_top
            assign w_above = w_step.push_code;
        end else begin : g_mid
            assign w_above = w_code[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_below = w_code[g];
        end else begin : g_up
            assign w_below = w_code[g+1];
        end
        sws_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_above (w_above),
            .i_below (w_below),
            .o_code  (w_code[g])
        );
    end

    always_comb begin
        n_count = r_count;
        n_esc   = r_esc;
        if (w_accept) begin
            n_esc = w_step.esc_next;
            if (w_step.clear) begin
                n_count = '0;
            end else if (w_step.op.push) begin
                n_count = r_count + CW'(1);
            end else if (w_step.op.pop) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    assign w_count_ext = {5'b0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_esc   <= n_esc;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action  <= w_step.action;
            r_key     <= i_key;
            r_nesting <= w_count_ext[4:0];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_action  = r_action;
    assign o_key_out = r_key;
    assign o_nesting = r_nesting;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("stack count beyond depth");

    a_eoi_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == KIND_EOI) |=>
            (o_valid && o_nesting == 5'd0 && o_action == ACT_CLOSE && r_count == '0))
        else $error("end of input did not clear state");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == ACT_OVERFLOW) |-> (r_count == FULL_COUNT))
        else $error("overflow reported with stack not full");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_step.op.push && w_step.op.pop))
        else $error("push and pop in the same beat");
`endif

endmodule

>>> rtl/sws_cell.sv
// sws_cell: one entry of the bracket and quote stack.
// Shifts toward the bottom on push and toward the top on pop.
// Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_cell
    import sws_pkg::*;
(
    input  logic       i_clk,
    input  t_stack_op  i_op,
    input  logic [2:0] i_above,
    input  logic [2:0] i_below,
    output logic [2:0] o_code
);

    logic [2:0] r_code;
    logic [2:0] n_code;

    always_comb begin
        n_code = r_code;
        if (i_op.push) begin
            n_code = i_above;
        end else if (i_op.pop) begin
            n_code = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

>>> rtl/sws_ctrl.sv
// sws_ctrl: classifies one beat against the stack top and escape flag.
// Produces the action code and the stack and flag updates.
// Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_ctrl
    import sws_pkg::*;
(
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_key,
    input  logic [2:0]  i_top,
    input  t_stack_stat i_stat,
    input  logic        i_esc,
    output t_step       o_step
);

    logic [2:0] w_top;
    logic [2:0] w_oc;
    logic       w_closer;
    logic       w_blank;
    logic       w_top_quote;
    logic [7:0] w_match;
    logic       w_match_ok;

    always_comb begin
        case (i_key)
            CH_LPAREN:  w_oc = CODE_PAREN;
            CH_LSQUARE: w_oc = CODE_SQUARE;
            CH_LCURLY:  w_oc = CODE_CURLY;
            CH_BTICK:   w_oc = CODE_BTICK;
            CH_SQUOTE:  w_oc = CODE_SQUOTE;
            CH_DQUOTE:  w_oc = CODE_DQUOTE;
            default:    w_oc = CODE_NONE;
        endcase
    end

    always_comb begin
        case (w_top)
            CODE_PAREN:  w_match = CH_RPAREN;
            CODE_SQUARE: w_match = CH_RSQUARE;
            CODE_CURLY:  w_match = CH_RCURLY;
            default:     w_match = 8'h00;
        endcase
    end

    assign w_top       = i_stat.empty ? CODE_NONE : i_top;
    assign w_closer    = (i_key == CH_RPAREN) || (i_key == CH_RSQUARE)
                      || (i_key == CH_RCURLY);
    assign w_blank     = (i_key == CH_SPACE) || (i_key == CH_TAB) || (i_key == CH_NL);
    assign w_top_quote = (w_top == CODE_BTICK) || (w_top == CODE_SQUOTE)
                      || (w_top == CODE_DQUOTE);
    assign w_match_ok  = (w_top == CODE_PAREN) || (w_top == CODE_SQUARE)
                      || (w_top == CODE_CURLY);

    always_comb begin
        o_step           = '0;
        o_step.esc_next  = i_esc;
        o_step.push_code = w_oc;
        o_step.action    = ACT_SYNTAX;
        unique case (i_kind)
            KIND_CHAR: begin
                if (i_key == CH_BACKSLASH && w_top != CODE_SQUOTE) begin
                    o_step.esc_next = !i_esc;
                    o_step.action   = i_esc ? ACT_KEPT : ACT_SYNTAX;
                end else if (w_blank && !w_top_quote) begin
                    o_step.esc_next = 1'b0;
                    o_step.action   = i_esc ? ACT_KEPT : ACT_CLOSE;
                end else if (w_oc == CODE_NONE && !w_closer) begin
                    o_step.esc_next = 1'b0;
                    o_step.action   = ACT_KEPT;
                end else if (w_top != CODE_SQUOTE && i_esc) begin
                    o_step.esc_next = 1'b0;
                    o_step.action   = ACT_KEPT;
                end else begin
                    o_step.esc_next = 1'b0;
                    if (w_top_quote) begin
                        if (w_oc == w_top) begin
                            o_step.op.pop = 1'b1;
                            o_step.action = ACT_SYNTAX;
                        end else begin
                            o_step.action = ACT_KEPT;
                        end
                    end else if (w_match_ok && i_key == w_match) begin
                        o_step.op.pop = 1'b1;
                        o_step.action = ACT_SYNTAX;
                    end else if (w_closer) begin
                        o_step.action = ACT_UNMATCHED;
                    end else if (i_stat.full) begin
                        o_step.action = ACT_OVERFLOW;
                    end else begin
                        o_step.op.push = 1'b1;
                        o_step.action  = ACT_SYNTAX;
                    end
                end
            end
            KIND_LINE: begin
                o_step.esc_next = 1'b0;
                o_step.action   = ACT_CLOSE;
            end
            KIND_EOI: begin
                o_step.esc_next = 1'b0;
                o_step.clear    = 1'b1;
                o_step.action   = ACT_CLOSE;
            end
            default: begin
                o_step.action = ACT_SYNTAX;
            end
        endcase
    end

endmodule
